/* rtl/core/frame_rate_time_converter_assert.svh */
// Assertion macros shared by the frame rate time converter.
`ifndef FRAME_RATE_TIME_CONVERTER_ASSERT_SVH
`define FRAME_RATE_TIME_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frtc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frtc: next-cycle check failed");

`endif

/* rtl/core/frtc_pkg.sv */
// Types, codes and constants shared by the frame rate time converter.
package frtc_pkg;

    localparam int RATE_BITS_DEF = 32;
    localparam int TICKS_DEF     = 1000000;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int VAL_W         = 63;
    localparam int OPND_W        = 64;

    localparam logic [1:0] ACT_FRAME_TO_TIME = 2'd0;
    localparam logic [1:0] ACT_TIME_TO_FRAME = 2'd1;
    localparam logic [1:0] ACT_INTERVAL      = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_ARG  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEN = 2'd1;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [OPND_W-1:0] operand;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] result_value;
        logic [1:0]       status;
    } t_out;

    // Control travelling with an item down the pipeline.
    typedef struct packed {
        logic       valid;
        logic       use_num;
        logic       round_up;
        logic [1:0] status;
    } t_ctl;

endpackage

/* rtl/core/frtc_mul.sv */
// Two-stage chunked multiplier with a side band carried alongside.
module frtc_mul #(
    parameter int AW = 63,
    parameter int BW = 32,
    parameter int SW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [AW+BW-1:0] o_p,
    output logic [SW-1:0]    o_side,
    output logic             o_busy
);
    localparam int NC = (AW + 31) / 32;
    localparam int XW = NC * 32;
    localparam int PW = AW + BW;

    logic [XW-1:0]    w_a_ext;
    logic [31+BW:0]   r_prod [NC];
    logic             r_s1_valid;
    logic [SW-1:0]    r_s1_side;
    logic [XW+BW-1:0] n_acc;
    logic             r_valid;
    logic [PW-1:0]    r_p;
    logic [SW-1:0]    r_side;

    assign w_a_ext = XW'(i_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_valid    <= r_s1_valid;
        end
    end

    // Each 32-bit slice of the wide operand gets its own multiplier.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NC; c++) begin
            r_prod[c] <= w_a_ext[c*32 +: 32] * i_b;
        end
        r_s1_side <= i_side;
        r_p       <= n_acc[PW-1:0];
        r_side    <= r_s1_side;
    end

    always_comb begin
        n_acc = '0;
        for (int c = 0; c < NC; c++) begin
            n_acc = n_acc + ((XW+BW)'(r_prod[c]) << (32 * c));
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;
    assign o_side  = r_side;
    assign o_busy  = r_s1_valid | r_valid;
endmodule

/* rtl/core/frtc_cell.sv */
// One restoring division step: yields one quotient bit per item per cycle.
module frtc_cell #(
    parameter int DW = 50
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  frtc_pkg::t_ctl                  i_ctl,
    input  logic [DW-1:0]                   i_rem,
    input  logic [frtc_pkg::VAL_W-1:0]      i_nq,
    input  logic [DW-1:0]                   i_num,
    input  logic [DW-1:0]                   i_den_ticks,
    output frtc_pkg::t_ctl                  o_ctl,
    output logic [DW-1:0]                   o_rem,
    output logic [frtc_pkg::VAL_W-1:0]      o_nq
);
    logic [DW:0]                   w_div;
    logic [DW:0]                   w_trial;
    logic [DW:0]                   w_diff;
    logic                          w_ge;
    logic [DW-1:0]                 n_rem;
    logic [frtc_pkg::VAL_W-1:0]    n_nq;
    frtc_pkg::t_ctl                r_ctl;
    logic [DW-1:0]                 r_rem;
    logic [frtc_pkg::VAL_W-1:0]    r_nq;

    always_comb begin
        w_div   = i_ctl.use_num ? {1'b0, i_num} : {1'b0, i_den_ticks};
        w_trial = {i_rem, i_nq[frtc_pkg::VAL_W-1]};
        w_diff  = w_trial - w_div;
        w_ge    = (w_trial >= w_div);
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        // Dividend bits leave at the top while quotient bits enter at the bottom.
        n_nq    = {i_nq[frtc_pkg::VAL_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_nq  <= n_nq;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
endmodule

/* rtl/core/frame_rate_time_converter.sv */
// Top level of the frame rate time converter: pipelined multiply and division chain.
//
// Channel   Direction  Handshake                     Payload
// command   in         start & !busy                 i_item (action, operand)
// result    out        o_result_stb, one cycle       o_result (result_value, status)
// config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// One conversion is accepted in every cycle; its result passes through two
// two-stage multipliers, one overflow check stage, one division cell per
// quotient bit (63) and the output register. Reset is synchronous and active
// low; busy is high during reset and in the first cycle after it. The receiver
// cannot stall, so nothing in the pipeline ever waits.
//
// Every action is reduced to one exact quotient of a product by a divisor.
// Frame to time computes ceil(frame * den * ticks / num), time to frame
// computes floor(time * num / (den * ticks)), and the interval computes
// ceil(den * ticks / num). The two nested floors of time to frame collapse
// into one, so a single division serves all three. The product is built by a
// multiplier by the rate register and a second multiplier by the tick count.
// The upper part of the product is then compared with the divisor: if it is
// not smaller, the quotient cannot fit in 63 bits and the item is flagged as
// overflowing. Otherwise it becomes the first partial remainder, and a chain
// of identical cells shifts in the lower 63 product bits, one per cell,
// producing one quotient bit each. A rounded-up quotient that reaches 2^63
// also counts as overflow.
//
// The configuration channel is ready only while the pipeline is empty and no
// command is offered, so a rate never changes under a transfer in flight. The
// product of the denominator and the tick count is refreshed from the
// register in every cycle; it is first used several stages after acceptance.
module frame_rate_time_converter #(
    parameter int RATE_BITS        = frtc_pkg::RATE_BITS_DEF,
    parameter int TICKS_PER_SECOND = frtc_pkg::TICKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  frtc_pkg::t_in                   i_item,
    output logic                            o_result_stb,
    output frtc_pkg::t_out                  o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [frtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [frtc_pkg::CFG_W-1:0]      i_cfg_data
);
    `include "frame_rate_time_converter_assert.svh"

    // Stored rate width: the configuration data is never wider than the port.
    localparam int CW   = (RATE_BITS < frtc_pkg::CFG_W) ? RATE_BITS : frtc_pkg::CFG_W;
    localparam int TW   = $clog2(TICKS_PER_SECOND + 1);
    localparam int DW   = CW + TW;
    localparam int VW   = frtc_pkg::VAL_W;
    localparam int P1W  = VW + CW;
    localparam int NW   = P1W + TW;
    localparam int CTW  = $bits(frtc_pkg::t_ctl);
    localparam int LAT  = 2 + 2 + 1 + VW + 1;
    localparam logic [TW-1:0] TICKS = TW'(TICKS_PER_SECOND);

    // Configuration registers.
    logic [CW-1:0] r_num;
    logic [CW-1:0] r_den;
    logic [DW-1:0] r_den_ticks;
    logic          r_busy;
    logic          w_pipe_busy;
    logic [DW-1:0] w_num_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= CW'(1);
            r_den  <= CW'(1);
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    frtc_pkg::REG_NUM: r_num <= i_cfg_data[CW-1:0];
                    frtc_pkg::REG_DEN: r_den <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_den_ticks <= r_den * TICKS;
    end

    assign w_num_ext   = DW'(r_num);
    assign busy        = r_busy;
    assign o_cfg_ready = !w_pipe_busy && !r_busy && !start;

    // Command decode: pick the multiplier operands, the divisor and any early status.
    logic              w_accept;
    frtc_pkg::t_ctl    d_ctl;
    logic [VW-1:0]     d_a;
    logic [CW-1:0]     d_b;
    logic [TW-1:0]     d_t;

    assign w_accept = start && !busy;

    always_comb begin
        d_ctl.valid    = w_accept;
        d_ctl.use_num  = (i_item.action != frtc_pkg::ACT_TIME_TO_FRAME);
        d_ctl.round_up = (i_item.action != frtc_pkg::ACT_TIME_TO_FRAME);
        case (i_item.action)
            frtc_pkg::ACT_FRAME_TO_TIME: begin
                d_ctl.status = i_item.operand[frtc_pkg::OPND_W-1] ? frtc_pkg::STAT_BAD_ARG :
                               (r_num == '0) ? frtc_pkg::STAT_OVERFLOW : frtc_pkg::STAT_OK;
            end
            frtc_pkg::ACT_TIME_TO_FRAME: begin
                d_ctl.status = i_item.operand[frtc_pkg::OPND_W-1] ? frtc_pkg::STAT_BAD_ARG :
                               (r_den == '0) ? frtc_pkg::STAT_OVERFLOW : frtc_pkg::STAT_OK;
            end
            frtc_pkg::ACT_INTERVAL: begin
                d_ctl.status = (r_num == '0) ? frtc_pkg::STAT_OVERFLOW : frtc_pkg::STAT_OK;
            end
            default: begin
                d_ctl.status = frtc_pkg::STAT_BAD_ARG;
            end
        endcase
        d_a = (i_item.action == frtc_pkg::ACT_INTERVAL) ? VW'(1) : i_item.operand[VW-1:0];
        d_b = (i_item.action == frtc_pkg::ACT_TIME_TO_FRAME) ? r_num : r_den;
        d_t = (i_item.action == frtc_pkg::ACT_TIME_TO_FRAME) ? TW'(1) : TICKS;
    end

    // First multiplier: operand times rate register.
    logic               m1_valid;
    logic [P1W-1:0]     m1_p;
    logic [CTW+TW-1:0]  m1_side;
    logic               m1_busy;
    frtc_pkg::t_ctl     m1_ctl;
    logic [TW-1:0]      m1_t;

    frtc_mul #(.AW(VW), .BW(CW), .SW(CTW + TW)) u_mul_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_a     (d_a),
        .i_b     (d_b),
        .i_side  ({d_ctl, d_t}),
        .o_valid (m1_valid),
        .o_p     (m1_p),
        .o_side  (m1_side),
        .o_busy  (m1_busy)
    );

    assign m1_ctl = frtc_pkg::t_ctl'(m1_side[TW +: CTW]);
    assign m1_t   = m1_side[TW-1:0];

    // Second multiplier: by the tick count, or by one for time to frame.
    logic               m2_valid;
    logic [NW-1:0]      m2_p;
    logic [CTW-1:0]     m2_side;
    logic               m2_busy;
    frtc_pkg::t_ctl     m2_ctl;

    frtc_mul #(.AW(P1W), .BW(TW), .SW(CTW)) u_mul_ticks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m1_valid),
        .i_a     (m1_p),
        .i_b     (m1_t),
        .i_side  (m1_ctl),
        .o_valid (m2_valid),
        .o_p     (m2_p),
        .o_side  (m2_side),
        .o_busy  (m2_busy)
    );

    assign m2_ctl = frtc_pkg::t_ctl'(m2_side);

    // Overflow check: the upper product bits must be below the divisor.
    logic [DW-1:0]     h_div;
    logic [DW-1:0]     h_hi;
    frtc_pkg::t_ctl    h_ctl;
    frtc_pkg::t_ctl    r_h_ctl;
    logic [DW-1:0]     r_h_rem;
    logic [VW-1:0]     r_h_nq;

    always_comb begin
        h_div          = m2_ctl.use_num ? w_num_ext : r_den_ticks;
        h_hi           = m2_p[NW-1:VW];
        h_ctl          = m2_ctl;
        h_ctl.valid    = m2_valid;
        if (m2_ctl.status == frtc_pkg::STAT_OK && h_hi >= h_div) begin
            h_ctl.status = frtc_pkg::STAT_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_ctl <= '0;
        end else begin
            r_h_ctl <= h_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_rem <= h_hi;
        r_h_nq  <= m2_p[VW-1:0];
    end

    // Division chain: one cell per quotient bit.
    frtc_pkg::t_ctl  c_ctl [VW+1];
    logic [DW-1:0]   c_rem [VW+1];
    logic [VW-1:0]   c_nq  [VW+1];
    logic [VW-1:0]   w_cell_valid;

    assign c_ctl[0] = r_h_ctl;
    assign c_rem[0] = r_h_rem;
    assign c_nq[0]  = r_h_nq;

    for (genvar g = 0; g < VW; g++) begin : g_cell
        frtc_cell #(.DW(DW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (c_ctl[g]),
            .i_rem       (c_rem[g]),
            .i_nq        (c_nq[g]),
            .i_num       (w_num_ext),
            .i_den_ticks (r_den_ticks),
            .o_ctl       (c_ctl[g+1]),
            .o_rem       (c_rem[g+1]),
            .o_nq        (c_nq[g+1])
        );
        assign w_cell_valid[g] = c_ctl[g+1].valid;
    end

    // Rounding and result forming.
    logic [VW:0]       f_sum;
    logic [1:0]        f_status;
    logic              r_stb;
    frtc_pkg::t_out    r_out;

    always_comb begin
        f_sum = {1'b0, c_nq[VW]} +
                (VW+1)'(c_ctl[VW].round_up && (c_rem[VW] != '0));
        if (c_ctl[VW].status != frtc_pkg::STAT_OK) begin
            f_status = c_ctl[VW].status;
        end else if (f_sum[VW]) begin
            f_status = frtc_pkg::STAT_OVERFLOW;
        end else begin
            f_status = frtc_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= c_ctl[VW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.status       <= f_status;
        r_out.result_value <= (f_status == frtc_pkg::STAT_OK) ? f_sum[VW-1:0] : '0;
    end

    assign o_result_stb = r_stb;
    assign o_result     = r_out;
    assign w_pipe_busy  = m1_busy | m2_busy | r_h_ctl.valid | (|w_cell_valid) | r_stb;

    // Checks.
    `FRTC_ASSERT_IMP(a_zero_on_error, i_clk, i_rst_n,
        o_result_stb && o_result.status != frtc_pkg::STAT_OK, o_result.result_value == '0)
    `FRTC_ASSERT_IMP(a_fixed_latency, i_clk, i_rst_n,
        o_result_stb, $past(start && !busy, LAT))
    `FRTC_ASSERT_NXT(a_cfg_closed, i_clk, i_rst_n,
        start && !busy, !o_cfg_ready)
endmodule
